/* design/gifad_pkg.sv */
package gifad_pkg;

  // Parse phases of the byte walker
  typedef enum logic [3:0] {
    PH_SIG       = 4'd0,
    PH_VER       = 4'd1,
    PH_SCREEN    = 4'd2,
    PH_SCREEN_T  = 4'd3,
    PH_SKIP_GCT  = 4'd4,
    PH_BLOCKS    = 4'd5,
    PH_EXT_LABEL = 4'd6,
    PH_EXT_SIZE  = 4'd7,
    PH_SKIP_EXT  = 4'd8,
    PH_IMG_DESC  = 4'd9,
    PH_SKIP_LCT  = 4'd10,
    PH_LZW       = 4'd11,
    PH_IMG_SIZE  = 4'd12,
    PH_SKIP_IMG  = 4'd13,
    PH_DONE      = 4'd14
  } phase_t;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_FRAMES  = 2'd0,
    ST_TERM    = 2'd1,
    ST_END     = 2'd2,
    ST_BAD_SIG = 2'd3
  } verdict_status_t;

  localparam int COLOR_ENTRY_BYTES_DEF = 3;

  localparam logic [3:0] FRAMES_RESET = 4'd2;
  localparam logic [3:0] COUNT_MAX    = 4'd15;

  // Block introducer bytes
  localparam logic [7:0] BYTE_TRAILER = 8'h3B;  // ';'
  localparam logic [7:0] BYTE_EXT     = 8'h21;  // '!'
  localparam logic [7:0] BYTE_IMAGE   = 8'h2C;  // ','

  // Header field positions
  localparam logic [3:0] SIG_LAST_IDX    = 4'd2;
  localparam logic [3:0] SCREEN_PACK_IDX = 4'd4;
  localparam logic [3:0] SCREEN_LAST_IDX = 4'd6;
  localparam logic [3:0] DESC_LAST_IDX   = 4'd8;

  // Expected signature byte per position
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    case (idx)
      4'd0:    sig_byte = 8'h47;  // 'G'
      4'd1:    sig_byte = 8'h49;  // 'I'
      4'd2:    sig_byte = 8'h46;  // 'F'
      default: sig_byte = 8'h47;
    endcase
  endfunction

endpackage

/* design/gifad_in_if.sv */
interface gifad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

/* design/gifad_out_if.sv */
interface gifad_out_if;
  logic       valid;
  logic       ready;
  logic       is_animation;
  logic [1:0] verdict_status;
  logic [3:0] frames_seen;

  modport source (output valid, output is_animation, output verdict_status,
                  output frames_seen, input ready);
  modport sink   (input valid, input is_animation, input verdict_status,
                  input frames_seen, output ready);
endinterface

/* design/gif_animation_detector_core.sv */
// A verdict is registered and visible on the output channel in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the parser state updates on every input transfer.
// While a verdict waits in the output register and is not taken, input transfers stall;
// the input side is free again in the cycle the verdict transfers out.
// Reset (rst, synchronous, active high) clears the parser, drops the output valid
// and sets the frame threshold to 2.
module gif_animation_detector_core
  import gifad_pkg::*;
#(
  parameter int COLOR_ENTRY_BYTES = COLOR_ENTRY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  gifad_in_if.sink     in_ch,
  gifad_out_if.source  out_ch
);

  localparam int PROD_W = 12;

  phase_t     phase, phase_next;
  logic [3:0] idx, idx_next;
  logic [9:0] skip, skip_next;
  logic [3:0] count, count_next;
  logic       given, given_next;
  logic [3:0] thresh;

  logic            verdict;
  verdict_status_t status;
  logic            anim;
  logic [3:0]      frames;
  logic            accept;
  logic [7:0]      b;

  logic            out_valid;
  logic            out_anim;
  verdict_status_t out_status;
  logic [3:0]      out_frames;

  // Color table length in bytes, minus one, kept to 10 bits
  function automatic logic [9:0] table_skip(input logic [2:0] size_code);
    logic [PROD_W-1:0] entries;
    logic [PROD_W-1:0] bytes;
    entries = PROD_W'(2) << size_code;
    bytes   = entries * PROD_W'(COLOR_ENTRY_BYTES);
    table_skip = 10'(bytes - PROD_W'(1));
  endfunction

  assign b      = in_ch.data_byte;
  assign accept = in_ch.valid && in_ch.ready;

  // Output register frees up when empty or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;

  // Parser next state and verdict
  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    skip_next  = skip;
    count_next = count;
    given_next = given;
    verdict    = 1'b0;
    status     = ST_FRAMES;
    anim       = 1'b0;

    case (phase)
      PH_SIG: begin
        if (b != sig_byte(idx)) begin
          verdict = 1'b1;
          status  = ST_BAD_SIG;
        end else if (idx >= SIG_LAST_IDX) begin
          idx_next   = '0;
          phase_next = PH_VER;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_VER: begin
        if (idx >= SIG_LAST_IDX) begin
          idx_next   = '0;
          phase_next = PH_SCREEN;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_SCREEN, PH_SCREEN_T: begin
        if (idx == SCREEN_PACK_IDX && b[7]) begin
          skip_next  = table_skip(b[2:0]);
          phase_next = PH_SCREEN_T;
        end
        if (idx >= SCREEN_LAST_IDX) begin
          idx_next   = '0;
          phase_next = (phase_next == PH_SCREEN_T) ? PH_SKIP_GCT : PH_BLOCKS;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_SKIP_GCT: begin
        if (skip == '0) phase_next = PH_BLOCKS;
        else skip_next = skip - 10'd1;
      end
      PH_BLOCKS: begin
        if (b == BYTE_TRAILER) begin
          verdict = 1'b1;
          status  = ST_TERM;
          anim    = (count >= thresh);
        end else if (b == BYTE_EXT) begin
          phase_next = PH_EXT_LABEL;
        end else if (b == BYTE_IMAGE) begin
          count_next = (count < COUNT_MAX) ? count + 4'd1 : count;
          if (count_next >= thresh) begin
            verdict = 1'b1;
            status  = ST_FRAMES;
            anim    = 1'b1;
          end else begin
            idx_next   = '0;
            phase_next = PH_IMG_DESC;
          end
        end
      end
      PH_EXT_LABEL: phase_next = PH_EXT_SIZE;
      PH_EXT_SIZE: begin
        if (b == 8'd0) begin
          phase_next = PH_BLOCKS;
        end else begin
          skip_next  = 10'(b - 8'd1);
          phase_next = PH_SKIP_EXT;
        end
      end
      PH_SKIP_EXT: begin
        if (skip == '0) phase_next = PH_EXT_SIZE;
        else skip_next = skip - 10'd1;
      end
      PH_IMG_DESC: begin
        if (idx >= DESC_LAST_IDX) begin
          idx_next = '0;
          if (b[7]) begin
            skip_next  = table_skip(b[2:0]);
            phase_next = PH_SKIP_LCT;
          end else begin
            phase_next = PH_LZW;
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_SKIP_LCT: begin
        if (skip == '0) phase_next = PH_LZW;
        else skip_next = skip - 10'd1;
      end
      PH_LZW: phase_next = PH_IMG_SIZE;
      PH_IMG_SIZE: begin
        if (b == 8'd0) begin
          phase_next = PH_BLOCKS;
        end else begin
          skip_next  = 10'(b - 8'd1);
          phase_next = PH_SKIP_IMG;
        end
      end
      PH_SKIP_IMG: begin
        if (skip == '0) phase_next = PH_IMG_SIZE;
        else skip_next = skip - 10'd1;
      end
      default: ;
    endcase

    // One verdict per stream; end of data reports if nothing else did
    if (verdict) begin
      given_next = 1'b1;
      phase_next = PH_DONE;
    end else if (in_ch.end_of_stream && !given) begin
      verdict = 1'b1;
      status  = ST_END;
      anim    = (count_next >= thresh);
    end

    // Frame count reported with the verdict, taken before the rearm
    frames = count_next;

    // Rearm for the next file
    if (in_ch.end_of_stream) begin
      phase_next = PH_SIG;
      idx_next   = '0;
      skip_next  = '0;
      count_next = '0;
      given_next = 1'b0;
    end
  end

  // Parser state and threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SIG;
      idx    <= '0;
      skip   <= '0;
      count  <= '0;
      given  <= 1'b0;
      thresh <= FRAMES_RESET;
    end else begin
      if (cfg_wr_en) thresh <= cfg_wr_data;
      if (accept) begin
        phase <= phase_next;
        idx   <= idx_next;
        skip  <= skip_next;
        count <= count_next;
        given <= given_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && verdict) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && verdict) begin
      out_anim   <= anim;
      out_status <= status;
      out_frames <= frames;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.is_animation   = out_anim;
  assign out_ch.verdict_status = out_status;
  assign out_ch.frames_seen    = out_frames;

endmodule

/* design/gifad_checker.sv */
module gifad_checker
  import gifad_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_animation,
  input logic [1:0] verdict_status,
  input logic [3:0] frames_seen
);

  // Stalled verdict holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict_status)
      && $stable(is_animation) && $stable(frames_seen))
    else $error("verdict changed while stalled");

  // Input side never stalls while no verdict is pending
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Bad signature comes before any image and is never an animation
  a_bad_sig: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_status == ST_BAD_SIG |-> !is_animation && frames_seen == 4'd0)
    else $error("bad signature verdict with frames or animation flag");

  // Frame-count verdict always reports an animation with at least one image
  a_frames: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_status == ST_FRAMES |-> is_animation && frames_seen != 4'd0)
    else $error("frame-count verdict without animation");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gif_animation_detector_core gifad_checker u_gifad_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .is_animation   (out_ch.is_animation),
  .verdict_status (out_ch.verdict_status),
  .frames_seen    (out_ch.frames_seen)
);
